// File: rtl/core/dbam_pkg.sv
// ----------------------------------------------------------------------------
// dbam_pkg
// Shared types and constants for the disk block allocation map.
// ----------------------------------------------------------------------------
package dbam_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int GROUP_SIZE = 16;
    localparam int WORD_W     = 64;                      // marks per map word
    localparam int BLK_W      = 12;                      // block number width
    localparam int CNT_W      = 13;                      // count / size width
    localparam int GRP_W      = $clog2(GROUP_SIZE);

    // opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_FIND    = 2'd2;
    localparam logic [1:0] OP_BOUNDED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // config register indexes
    localparam logic REG_DISK_BLOCKS = 1'b0;
    localparam logic REG_GROUPING    = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NAMED_RD,
        S_NAMED,
        S_MOD,
        S_SCAN_START,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// File: rtl/core/dbam_rem.sv
// ----------------------------------------------------------------------------
// dbam_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbam_rem
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [dbam_pkg::CNT_W-1:0] dividend,
    input  logic [dbam_pkg::CNT_W-1:0] divisor,
    output logic                     done,
    output logic [dbam_pkg::CNT_W-1:0] remainder
);

    localparam int W     = dbam_pkg::CNT_W;
    localparam int STEPW = $clog2(W + 1);

    logic [W-1:0]     dvd_reg;
    logic [W-1:0]     dvs_reg;
    logic [W-1:0]     rem_reg;
    logic [STEPW-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEPW'(1);
                if (cnt_reg == STEPW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
                rem_reg <= diff[W-1:0];
            else
                rem_reg <= trial[W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/disk_block_allocation_map.sv
// ----------------------------------------------------------------------------
// disk_block_allocation_map
// Free-block bitmap with named allocate/free, circular next-fit search and
// bounded-window allocate. Marks live in a word-wide map memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// input    in         in_valid / in_stall     opcode, block_or_start,
//                                             window_length, round_to_group
// result   out        out_valid / out_stall   status, granted_block, used_count
// config   in         cfg_wr_en               cfg_index, cfg_data
//
// Named allocate/free read the map word, then update the mark. Bounded allocate
// checks one map word (WORD_W marks) per cycle. Find first takes the start
// remainder from the 13-step bit-serial divider, then scans, the start word
// being read twice on a wrap.
// After reset a clearing pass writes every map word (ROWS words, 64 at the
// defaults) before the first transfer is taken.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block only holds in its done state if that is full.
// ----------------------------------------------------------------------------
module disk_block_allocation_map
#(
    parameter int WORD_W = dbam_pkg::WORD_W
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // config
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [dbam_pkg::CNT_W-1:0]  cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [dbam_pkg::BLK_W-1:0]  block_or_start,
    input  logic [dbam_pkg::CNT_W-1:0]  window_length,
    input  logic                        round_to_group,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [dbam_pkg::BLK_W-1:0]  granted_block,
    output logic [dbam_pkg::CNT_W-1:0]  used_count
);

    localparam int BLK_W = dbam_pkg::BLK_W;
    localparam int CNT_W = dbam_pkg::CNT_W;
    localparam int GRP_W = dbam_pkg::GRP_W;
    localparam int ROWS  = dbam_pkg::MAX_BLOCKS / WORD_W;
    localparam int BIT_W = $clog2(WORD_W);
    localparam int ROW_W = BLK_W - BIT_W;

    // ---------------- config
    logic [CNT_W-1:0] disk_blocks_reg;
    logic             grouping_reg;
    logic [CNT_W-1:0] n_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_blocks_reg <= CNT_W'(dbam_pkg::MAX_BLOCKS);
            grouping_reg    <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dbam_pkg::REG_DISK_BLOCKS: disk_blocks_reg <= cfg_data;
                dbam_pkg::REG_GROUPING:    grouping_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (disk_blocks_reg < CNT_W'(2))
            n_size = CNT_W'(2);
        else if (disk_blocks_reg > CNT_W'(dbam_pkg::MAX_BLOCKS))
            n_size = CNT_W'(dbam_pkg::MAX_BLOCKS);
        else
            n_size = disk_blocks_reg;
    end

    // ---------------- state
    dbam_pkg::state_t state_reg, state_next;

    logic [1:0]       op_reg;
    logic [BLK_W-1:0] pos_reg;
    logic [BLK_W-1:0] start_reg;
    logic [BLK_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic             phase_b_reg;
    logic [ROW_W-1:0] chk_row_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [CNT_W-1:0] used_reg;
    logic [1:0]       res_status_reg;
    logic [BLK_W-1:0] res_block_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [BLK_W-1:0] out_block_reg;
    logic [CNT_W-1:0] out_used_reg;

    // ---------------- map memory
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // ---------------- remainder unit
    logic             div_start;
    logic [CNT_W-1:0] div_dividend;
    logic             div_done;
    logic [CNT_W-1:0] div_rem;

    dbam_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (n_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    // ---------------- decode of the incoming item
    logic             in_xfer;
    logic             named_bad;
    logic [BLK_W-1:0] bnd_lo;
    logic [CNT_W:0]   bnd_sum;
    logic [CNT_W-1:0] bnd_hi;
    logic             bnd_empty;

    assign in_xfer   = in_valid && !in_stall;
    assign named_bad = (block_or_start == '0) || ({1'b0, block_or_start} >= n_size);
    assign bnd_lo    = (block_or_start == '0) ? BLK_W'(1) : block_or_start;
    assign bnd_sum   = {2'b00, block_or_start} + {1'b0, window_length};
    assign bnd_hi    = (bnd_sum > {1'b0, n_size}) ? n_size : bnd_sum[CNT_W-1:0];
    assign bnd_empty = ({1'b0, bnd_lo} >= bnd_hi);

    // group round-up: next multiple strictly above the start
    assign div_dividend = (round_to_group && grouping_reg)
                        ? CNT_W'({(CNT_W - GRP_W)'(block_or_start[BLK_W-1:GRP_W])
                                  + (CNT_W - GRP_W)'(1), {GRP_W{1'b0}}})
                        : {1'b0, block_or_start};

    // ---------------- word scan
    logic [ROW_W-1:0]  lo_row;
    logic [BIT_W-1:0]  lo_bit;
    logic [ROW_W:0]    hi_row;
    logic [BIT_W-1:0]  hi_bit;
    logic [WORD_W-1:0] scan_mask;
    logic              scan_found;
    logic [BIT_W-1:0]  scan_bit;
    logic [CNT_W-1:0]  next_base;
    logic              scan_last;
    logic              named_mark;
    logic [BIT_W-1:0]  pos_bit;

    assign lo_row    = lo_reg[BLK_W-1:BIT_W];
    assign lo_bit    = lo_reg[BIT_W-1:0];
    assign hi_row    = hi_reg[CNT_W-1:BIT_W];
    assign hi_bit    = hi_reg[BIT_W-1:0];
    assign next_base = {1'b0, chk_row_reg, {BIT_W{1'b0}}} + CNT_W'(WORD_W);
    assign scan_last = (next_base >= hi_reg);
    assign pos_bit   = pos_reg[BIT_W-1:0];
    assign named_mark = rd_data_reg[pos_bit];

    always_comb
    begin
        scan_mask = ~rd_data_reg;
        if (chk_row_reg == lo_row)
            scan_mask = scan_mask & ({WORD_W{1'b1}} << lo_bit);
        if ({1'b0, chk_row_reg} == hi_row)
            scan_mask = scan_mask & ~({WORD_W{1'b1}} << hi_bit);
    end

    always_comb
    begin
        scan_found = |scan_mask;
        scan_bit   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (scan_mask[i])
                scan_bit = BIT_W'(i);
        end
    end

    // ---------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dbam_pkg::S_CLEAR:
                if (clr_row_reg == ROW_W'(ROWS - 1))
                    state_next = dbam_pkg::S_IDLE;
            dbam_pkg::S_IDLE:
                if (in_valid)
                begin
                    case (opcode)
                        dbam_pkg::OP_ALLOC, dbam_pkg::OP_FREE:
                            state_next = named_bad ? dbam_pkg::S_DONE : dbam_pkg::S_NAMED_RD;
                        dbam_pkg::OP_FIND:
                            state_next = dbam_pkg::S_MOD;
                        default:
                            state_next = bnd_empty ? dbam_pkg::S_DONE
                                                   : dbam_pkg::S_SCAN_START;
                    endcase
                end
            dbam_pkg::S_NAMED_RD:
                state_next = dbam_pkg::S_NAMED;
            dbam_pkg::S_NAMED:
                state_next = dbam_pkg::S_DONE;
            dbam_pkg::S_MOD:
                if (div_done)
                    state_next = dbam_pkg::S_SCAN_START;
            dbam_pkg::S_SCAN_START:
                state_next = dbam_pkg::S_SCAN;
            dbam_pkg::S_SCAN:
                if (scan_found)
                    state_next = dbam_pkg::S_DONE;
                else if (scan_last)
                begin
                    if (op_reg == dbam_pkg::OP_FIND && !phase_b_reg
                        && start_reg > BLK_W'(1))
                        state_next = dbam_pkg::S_SCAN_START;
                    else
                        state_next = dbam_pkg::S_DONE;
                end
            dbam_pkg::S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = dbam_pkg::S_IDLE;
            default:
                state_next = dbam_pkg::S_IDLE;
        endcase
    end

    // ---------------- control outputs
    always_comb
    begin
        mem_raddr = chk_row_reg + ROW_W'(1);
        mem_we    = 1'b0;
        mem_waddr = chk_row_reg;
        mem_wdata = rd_data_reg | (WORD_W'(1) << scan_bit);
        div_start = 1'b0;
        case (state_reg)
            dbam_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_row_reg;
                mem_wdata = (clr_row_reg == '0) ? WORD_W'(1) : '0;
            end
            dbam_pkg::S_IDLE:
                div_start = in_xfer && (opcode == dbam_pkg::OP_FIND);
            dbam_pkg::S_NAMED_RD:
                mem_raddr = pos_reg[BLK_W-1:BIT_W];
            dbam_pkg::S_NAMED:
            begin
                // a successful allocate or free flips the mark
                mem_we    = (op_reg == dbam_pkg::OP_ALLOC) ? !named_mark : named_mark;
                mem_waddr = pos_reg[BLK_W-1:BIT_W];
                mem_wdata = rd_data_reg ^ (WORD_W'(1) << pos_bit);
            end
            dbam_pkg::S_SCAN_START:
                mem_raddr = lo_row;
            dbam_pkg::S_SCAN:
                mem_we = scan_found;
            default: ;
        endcase
    end

    assign in_stall = (state_reg != dbam_pkg::S_IDLE);

    // ---------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbam_pkg::S_CLEAR;
            clr_row_reg   <= '0;
            phase_b_reg   <= 1'b0;
            used_reg      <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dbam_pkg::S_CLEAR)
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (in_xfer)
                phase_b_reg <= 1'b0;
            else if (state_reg == dbam_pkg::S_SCAN && !scan_found && scan_last
                     && op_reg == dbam_pkg::OP_FIND)
                phase_b_reg <= 1'b1;
            if (state_reg == dbam_pkg::S_NAMED)
            begin
                if (op_reg == dbam_pkg::OP_ALLOC && !named_mark)
                    used_reg <= used_reg + CNT_W'(1);
                else if (op_reg == dbam_pkg::OP_FREE && named_mark)
                    used_reg <= used_reg - CNT_W'(1);
            end
            else if (state_reg == dbam_pkg::S_SCAN && scan_found)
                used_reg <= used_reg + CNT_W'(1);
            if (state_reg == dbam_pkg::S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            dbam_pkg::S_IDLE:
                if (in_xfer)
                begin
                    op_reg        <= opcode;
                    pos_reg       <= block_or_start;
                    lo_reg        <= bnd_lo;
                    hi_reg        <= bnd_hi;
                    res_block_reg <= '0;
                    if (opcode == dbam_pkg::OP_BOUNDED)
                        res_status_reg <= dbam_pkg::ST_NONE;
                    else
                        res_status_reg <= dbam_pkg::ST_RANGE;
                end
            dbam_pkg::S_NAMED:
            begin
                if (op_reg == dbam_pkg::OP_ALLOC)
                begin
                    res_status_reg <= named_mark ? dbam_pkg::ST_SAME : dbam_pkg::ST_OK;
                    res_block_reg  <= named_mark ? '0 : pos_reg;
                end
                else
                begin
                    res_status_reg <= named_mark ? dbam_pkg::ST_OK : dbam_pkg::ST_SAME;
                    res_block_reg  <= '0;
                end
            end
            dbam_pkg::S_MOD:
                if (div_done)
                begin
                    start_reg <= div_rem[BLK_W-1:0];
                    lo_reg    <= (div_rem == '0) ? BLK_W'(1) : div_rem[BLK_W-1:0];
                    hi_reg    <= n_size;
                end
            dbam_pkg::S_SCAN_START:
                chk_row_reg <= lo_row;
            dbam_pkg::S_SCAN:
            begin
                chk_row_reg <= chk_row_reg + ROW_W'(1);
                if (scan_found)
                begin
                    res_status_reg <= dbam_pkg::ST_OK;
                    res_block_reg  <= {chk_row_reg, scan_bit};
                end
                else if (scan_last)
                begin
                    // wrap part of the circular search: blocks 1 .. start-1
                    lo_reg         <= BLK_W'(1);
                    hi_reg         <= {1'b0, start_reg};
                    res_status_reg <= dbam_pkg::ST_NONE;
                    res_block_reg  <= '0;
                end
            end
            dbam_pkg::S_DONE:
                if (!out_valid_reg || !out_stall)
                begin
                    out_status_reg <= res_status_reg;
                    out_block_reg  <= res_block_reg;
                    out_used_reg   <= used_reg;
                end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_block = out_block_reg;
    assign used_count    = out_used_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(dbam_pkg::MAX_BLOCKS))
        else $error("used count above map size");

    a_scan_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbam_pkg::S_SCAN && scan_found)
        |=> used_reg == $past(used_reg) + CNT_W'(1))
        else $error("scan grant did not bump used count");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted_block != '0) |-> status == dbam_pkg::ST_OK)
        else $error("grant with failing status");

    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbam_pkg::S_CLEAR) |-> in_stall)
        else $error("input taken during clearing pass");
`endif

endmodule
